// ===== rtl/core/bmhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types, codes and widths of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam int KEY_W       = 64;
  localparam int SLOT_W      = 10;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 11;
  localparam int S_DATA_W    = 80;
  localparam int M_DATA_W    = 80;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_EXTRACT  = 2'd1,
    ACT_PEEK     = 2'd2,
    ACT_INCREASE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_SMALLER = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PEEK,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_INC_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMPR,
    S_DONE
  } state_t;

  // read address source
  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_SLOT,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // write data source (write address is always the hole position)
  typedef enum logic [1:0] {
    WD_KEY,
    WD_RD,
    WD_BIG
  } wd_sel_t;

  // hole position source
  typedef enum logic [2:0] {
    POS_COUNT,
    POS_ZERO,
    POS_SLOT,
    POS_PARENT,
    POS_LEFT,
    POS_RIGHT
  } pos_sel_t;

  typedef struct packed {
    logic     in_take;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wd_sel_t  wd_sel;
    logic     pos_en;
    pos_sel_t pos_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     key_from_rd;
    logic     big_load;
    logic     res_load;
    logic     st_en;
    status_t  st_code;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    action_t op;
    logic    full;
    logic    empty;
    logic    range_bad;
    logic    pos_zero;
    logic    l_ok;
    logic    r_ok;
    logic    key_lt_rd;
    logic    rd_lt_key;
    logic    big_lt_rd;
    logic    big_moved;
    logic    out_busy;
  } stat_t;

endpackage

// ===== rtl/core/bmhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bmhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Sequencer for the heap actions: decode, sift-up and sift-down walks.
// ----------------------------------------------------------------------------
module bmhpq_ctrl
  import bmhpq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.in_take = 1'b1;
          state_next  = S_START;
        end
      end

      S_START: begin
        unique case (stat.op)
          ACT_INSERT: begin
            if (stat.full) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_FULL;
              state_next  = S_DONE;
            end else begin
              cmd.pos_en  = 1'b1;
              cmd.pos_sel = POS_COUNT;
              cmd.cnt_inc = 1'b1;
              state_next  = S_UP_RD;
            end
          end
          ACT_EXTRACT: begin
            if (stat.empty) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ROOT;
              state_next = S_EXT_ROOT;
            end
          end
          ACT_PEEK: begin
            if (stat.empty) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ROOT;
              state_next = S_PEEK;
            end
          end
          ACT_INCREASE: begin
            if (stat.range_bad) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = ST_RANGE;
              state_next  = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_SLOT;
              state_next = S_INC_CHK;
            end
          end
        endcase
      end

      S_PEEK: begin
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
      end

      // take the root, fetch the last key and shrink the heap
      S_EXT_ROOT: begin
        cmd.res_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LAST;
        cmd.cnt_dec  = 1'b1;
        state_next   = S_EXT_LAST;
      end

      S_EXT_LAST: begin
        cmd.key_from_rd = 1'b1;
        cmd.pos_en      = 1'b1;
        cmd.pos_sel     = POS_ZERO;
        state_next      = S_DN_RDL;
      end

      S_INC_CHK: begin
        if (stat.key_lt_rd) begin
          cmd.st_en   = 1'b1;
          cmd.st_code = ST_SMALLER;
          state_next  = S_DONE;
        end else begin
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = POS_SLOT;
          state_next  = S_UP_RD;
        end
      end

      // sift-up: fetch the parent, or settle at the root
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wd_sel = WD_KEY;
          state_next = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end

      // move the parent down into the hole, or settle the key
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_lt_key) begin
          cmd.wd_sel  = WD_RD;
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = POS_PARENT;
          state_next  = S_UP_RD;
        end else begin
          cmd.wd_sel = WD_KEY;
          state_next = S_DONE;
        end
      end

      // sift-down: fetch the left child, or settle at a leaf
      S_DN_RDL: begin
        if (stat.l_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_RDR;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wd_sel = WD_KEY;
          state_next = S_DONE;
        end
      end

      // left child arrives; fetch the right one or decide now
      S_DN_RDR: begin
        if (stat.r_ok) begin
          cmd.big_load = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_RIGHT;
          state_next   = S_DN_CMPR;
        end else begin
          cmd.wr_en = 1'b1;
          if (stat.key_lt_rd) begin
            cmd.wd_sel  = WD_RD;
            cmd.pos_en  = 1'b1;
            cmd.pos_sel = POS_LEFT;
            state_next  = S_DN_RDL;
          end else begin
            cmd.wd_sel = WD_KEY;
            state_next = S_DONE;
          end
        end
      end

      // right child arrives; pick the largest of key, left and right
      S_DN_CMPR: begin
        cmd.wr_en = 1'b1;
        priority if (stat.big_lt_rd) begin
          cmd.wd_sel  = WD_RD;
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = POS_RIGHT;
          state_next  = S_DN_RDL;
        end else if (stat.big_moved) begin
          cmd.wd_sel  = WD_BIG;
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = POS_LEFT;
          state_next  = S_DN_RDL;
        end else begin
          cmd.wd_sel = WD_KEY;
          state_next = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bmhpq_dp.sv =====
// ----------------------------------------------------------------------------
// bmhpq_dp
// Heap datapath: key store, hole position, count, compares and result register.
// ----------------------------------------------------------------------------
module bmhpq_dp
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,   // key_value[63:0], slot_index[73:64], zero pad
  input  logic [ACTION_W-1:0] s_tuser,   // action[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // result_value[63:0], status[66:64],
                                         // entry_count[77:67], zero pad
  input  cmd_t                cmd,
  output stat_t               stat
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CHW  = AW + 2;
  localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

  action_t                   op;
  logic signed [KEY_W-1:0]   mov_key;
  logic [SLOT_W-1:0]         slot;
  logic [CW-1:0]             count;
  logic [AW-1:0]             pos;
  logic signed [KEY_W-1:0]   big_val;
  logic                      big_moved;
  logic signed [KEY_W-1:0]   res_value;
  status_t                   res_status;
  logic signed [KEY_W-1:0]   out_value;
  status_t                   out_status;
  logic [COUNT_OUT_W-1:0]    out_count;
  logic                      out_valid;

  logic [AW-1:0]             rd_addr;
  logic [KEY_W-1:0]          rd_raw;
  logic signed [KEY_W-1:0]   rd_data;
  logic [KEY_W-1:0]          wr_data;
  logic [AW-1:0]             parent;
  logic [CHW-1:0]            left;
  logic [CHW-1:0]            right;
  logic [AW-1:0]             pos_next;

  assign rd_data = $signed(rd_raw);
  assign parent  = AW'((pos - 1'b1) >> 1);
  assign left    = {1'b0, pos, 1'b1};
  assign right   = left + 1'b1;

  // key store
  bmhpq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(pos),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = AW'(count - 1'b1);
      RD_SLOT:   rd_addr = AW'(slot);
      RD_PARENT: rd_addr = parent;
      RD_LEFT:   rd_addr = AW'(left);
      RD_RIGHT:  rd_addr = AW'(right);
      default:   rd_addr = '0;
    endcase
  end

  // write data select
  always_comb begin
    case (cmd.wd_sel)
      WD_KEY:  wr_data = mov_key;
      WD_RD:   wr_data = rd_data;
      WD_BIG:  wr_data = big_val;
      default: wr_data = mov_key;
    endcase
  end

  // hole position select
  always_comb begin
    case (cmd.pos_sel)
      POS_COUNT:  pos_next = AW'(count);
      POS_ZERO:   pos_next = '0;
      POS_SLOT:   pos_next = AW'(slot);
      POS_PARENT: pos_next = parent;
      POS_LEFT:   pos_next = AW'(left);
      POS_RIGHT:  pos_next = AW'(right);
      default:    pos_next = pos;
    endcase
  end

  // item fields, moving key, hole and best-child registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      op      <= action_t'(s_tuser);
      mov_key <= $signed(s_tdata[KEY_W-1:0]);
      slot    <= s_tdata[KEY_W +: SLOT_W];
    end else if (cmd.key_from_rd) begin
      mov_key <= rd_data;
    end
    if (cmd.pos_en) begin
      pos <= pos_next;
    end
    if (cmd.big_load) begin
      big_moved <= (mov_key < rd_data);
      big_val   <= (mov_key < rd_data) ? rd_data : mov_key;
    end
  end

  // result value and status; cleared as each item is taken
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      res_value  <= '0;
      res_status <= ST_OK;
    end else begin
      if (cmd.res_load) begin
        res_value <= rd_data;
      end
      if (cmd.st_en) begin
        res_status <= cmd.st_code;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= COUNT_OUT_W'(count);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - KEY_W - STATUS_W - COUNT_OUT_W){1'b0}},
                     out_count, out_status, out_value};

  // status toward the controller
  always_comb begin
    stat           = '0;
    stat.op        = op;
    stat.full      = (count == CW'(CAPACITY));
    stat.empty     = (count == '0);
    stat.range_bad = (CMPW'(slot) >= CMPW'(count));
    stat.pos_zero  = (pos == '0);
    stat.l_ok      = (left < CHW'(count));
    stat.r_ok      = (right < CHW'(count));
    stat.key_lt_rd = (mov_key < rd_data);
    stat.rd_lt_key = (rd_data < mov_key);
    stat.big_lt_rd = (big_val < rd_data);
    stat.big_moved = big_moved;
    stat.out_busy  = out_valid && !m_tready;
  end

endmodule

// ===== rtl/core/binary_max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Insert and increase walk up the heap and extract walks down; peek and error results need
// no walk.
// Throughput: one item at a time; tready returns the cycle after the result loads.
// Reset: synchronous, clears the count and output valid; the key store holds junk.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // key_value[63:0], slot_index[73:64], zero pad
  input  logic [ACTION_W-1:0] s_tuser,   // action[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // result_value[63:0], status[66:64],
                                         // entry_count[77:67], zero pad
);

  cmd_t  cmd;
  stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  bmhpq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

  // one item in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in flight");

  // the store never sees a read and a write in the same cycle
  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("store read and write collide");

  // count never grows past capacity nor shrinks below zero
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("insert into full heap");

  a_count_shrink: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !stat.empty)
    else $error("extract from empty heap");

endmodule
